[rtl/core/ncle_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncle_pkg
// Shared widths, register indexes, feedback masks and the result type of the
// noise channel (LFSR with length counter and volume envelope).
// ----------------------------------------------------------------------------
package ncle_pkg;

   // Field and counter widths
   localparam int TICK_W      = 8;
   localparam int LFSR_W      = 15;
   localparam int SHIFT_W     = 20;
   localparam int LEN_W       = 21;
   localparam int ENV_CNT_W   = 19;
   localparam int VOL_W       = 4;
   localparam int SAMPLE_W    = 12;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 6;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LENGTH_LOAD     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INITIAL_VOLUME  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ENVELOPE_UP     = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ENVELOPE_PERIOD = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CLOCK_SHIFT     = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SHORT_MODE      = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DIVISOR_CODE    = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_LENGTH_ENABLE   = 4'd7;

   // Input commands
   localparam logic CMD_ADVANCE = 1'b0;
   localparam logic CMD_TRIGGER = 1'b1;

   // LFSR feedback masks: bit 14 only, or bits 14 and 6 in short mode
   localparam logic [LFSR_W-1:0] FB_LONG  = 15'h4000;
   localparam logic [LFSR_W-1:0] FB_SHORT = 15'h4040;

   // Reset values
   localparam logic [LFSR_W-1:0]  LFSR_RESET         = 15'd1;
   localparam logic [SHIFT_W-1:0] SHIFT_PERIOD_RESET = 20'd8;
   localparam logic [LEN_W-1:0]   LENGTH_LIMIT_RESET = 21'd8;

   // Largest shift before the "no shift" case
   localparam logic [4:0] MAX_SHIFT = 5'd14;

   // One result
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                channel_on;
      logic                noise_bit;
   } rsp_type;

endpackage

[rtl/core/noise_channel_lfsr_envelope.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// noise_channel_lfsr_envelope
// Noise sound channel: 15-bit LFSR at a programmable period, optional length
// counter and 4-bit volume envelope; one result per input item.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : register writes (index, data); always ready, one per cycle.
//            Write only while the channel has no item in flight.
//   req_*  : items; command trigger (start/stop by start_bit) or time
//            advance by tick_count ticks. Transfer when req_valid && !req_stall.
//   rsp_*  : one result per item, transfer when rsp_valid && !rsp_stall.
// An accepted item's result enters the output register at its edge, or the
// skid entry if that register is held. Throughput is one item per cycle while
// req_stall is low; the whole channel update happens in the accept cycle.
// The result side has an output register plus one skid entry. A stalled
// receiver fills the skid entry, and req_stall is raised while it is full,
// so at most two results wait. req_stall is a register output.
// Reset (synchronous): registers 0, channel stopped, LFSR = 1, shift period
// 8, length limit 8, all counters and the volume 0, no result pending.
// ----------------------------------------------------------------------------
module noise_channel_lfsr_envelope
   import ncle_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // configuration
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata,
   // input items
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_command,
   input  logic                      req_start_bit,
   input  logic [TICK_W-1:0]         req_tick_count,
   // results
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample,
   output logic                      rsp_channel_on,
   output logic                      rsp_noise_bit
);

   // Configuration registers
   logic [5:0] length_load_ff;
   logic [3:0] initial_volume_ff;
   logic       envelope_up_ff;
   logic [2:0] envelope_period_ff;
   logic [3:0] clock_shift_ff;
   logic       short_mode_ff;
   logic [2:0] divisor_code_ff;
   logic       length_enable_ff;

   // Channel state
   logic                 running_ff, running_in;
   logic [LFSR_W-1:0]    shift_reg_ff, shift_reg_in;
   logic [SHIFT_W-1:0]   shift_period_ff, shift_period_in;
   logic [SHIFT_W-1:0]   shift_count_ff, shift_count_in;
   logic                 short_latched_ff, short_latched_in;
   logic                 length_active_ff, length_active_in;
   logic [LEN_W-1:0]     length_limit_ff, length_limit_in;
   logic [LEN_W-1:0]     length_count_ff, length_count_in;
   logic                 envelope_active_ff, envelope_active_in;
   logic                 envelope_dir_ff, envelope_dir_in;
   logic [2:0]           envelope_step_ff, envelope_step_in;
   logic [ENV_CNT_W-1:0] envelope_count_ff, envelope_count_in;
   logic [VOL_W-1:0]     volume_ff, volume_in;

   // Output register and skid entry
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;

   logic    req_take;
   logic    out_free;
   rsp_type result;

   // Trigger-time values
   logic [5:0]         base_period;
   logic [4:0]         shift_amt;
   logic [6:0]         length_units;

   // Advance-time values
   logic [SHIFT_W:0]     sc_sum;
   logic [SHIFT_W-1:0]   sc_sat;
   logic                 fb_bit;
   logic [LFSR_W-1:0]    fb_mask;
   logic [LEN_W-1:0]     lc_sum;
   logic [ENV_CNT_W:0]   env_sum;
   logic [ENV_CNT_W:0]   env_step_ticks;
   logic [10:0]          magnitude;
   logic [SAMPLE_W-1:0]  mag_ext;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         length_load_ff     <= '0;
         initial_volume_ff  <= '0;
         envelope_up_ff     <= 1'b0;
         envelope_period_ff <= '0;
         clock_shift_ff     <= '0;
         short_mode_ff      <= 1'b0;
         divisor_code_ff    <= '0;
         length_enable_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_LENGTH_LOAD:     length_load_ff     <= csr_wdata[5:0];
            REG_INITIAL_VOLUME:  initial_volume_ff  <= csr_wdata[3:0];
            REG_ENVELOPE_UP:     envelope_up_ff     <= csr_wdata[0];
            REG_ENVELOPE_PERIOD: envelope_period_ff <= csr_wdata[2:0];
            REG_CLOCK_SHIFT:     clock_shift_ff     <= csr_wdata[3:0];
            REG_SHORT_MODE:      short_mode_ff      <= csr_wdata[0];
            REG_DIVISOR_CODE:    divisor_code_ff    <= csr_wdata[2:0];
            REG_LENGTH_ENABLE:   length_enable_ff   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Values latched by a start trigger
   always_comb begin
      base_period  = (divisor_code_ff == 3'd0) ? 6'd4 : {divisor_code_ff, 3'b000};
      shift_amt    = {1'b0, clock_shift_ff} + 5'd1;
      if (shift_amt > MAX_SHIFT) begin
         shift_amt = 5'd0;
      end
      length_units = 7'd64 - {1'b0, length_load_ff};
   end

   // Counter sums for a time advance
   always_comb begin
      sc_sum         = {1'b0, shift_count_ff} + {{(SHIFT_W + 1 - TICK_W){1'b0}}, req_tick_count};
      sc_sat         = sc_sum[SHIFT_W] ? {SHIFT_W{1'b1}} : sc_sum[SHIFT_W-1:0];
      fb_bit         = shift_reg_ff[0] ^ shift_reg_ff[1];
      fb_mask        = short_latched_ff ? FB_SHORT : FB_LONG;
      lc_sum         = length_count_ff + {{(LEN_W - TICK_W){1'b0}}, req_tick_count};
      env_sum        = {1'b0, envelope_count_ff}
                       + {{(ENV_CNT_W + 1 - TICK_W){1'b0}}, req_tick_count};
      env_step_ticks = {1'b0, envelope_step_ff, 16'h0000};
   end

   // Channel update for one item
   always_comb begin
      running_in         = running_ff;
      shift_reg_in       = shift_reg_ff;
      shift_period_in    = shift_period_ff;
      shift_count_in     = shift_count_ff;
      short_latched_in   = short_latched_ff;
      length_active_in   = length_active_ff;
      length_limit_in    = length_limit_ff;
      length_count_in    = length_count_ff;
      envelope_active_in = envelope_active_ff;
      envelope_dir_in    = envelope_dir_ff;
      envelope_step_in   = envelope_step_ff;
      envelope_count_in  = envelope_count_ff;
      volume_in          = volume_ff;

      if (req_command == CMD_TRIGGER) begin
         // start reloads everything but the LFSR; stop only clears running
         running_in = req_start_bit;
         if (req_start_bit) begin
            shift_period_in    = {{(SHIFT_W - 6){1'b0}}, base_period} << shift_amt;
            shift_count_in     = '0;
            short_latched_in   = short_mode_ff;
            length_active_in   = length_enable_ff;
            length_limit_in    = {length_units, 14'h0000};
            length_count_in    = '0;
            envelope_step_in   = envelope_period_ff;
            envelope_active_in = (envelope_period_ff != 3'd0);
            envelope_dir_in    = envelope_up_ff;
            volume_in          = initial_volume_ff;
            envelope_count_in  = '0;
         end
      end else if (running_ff) begin
         // LFSR: at most one shift per item
         if (shift_period_ff != '0) begin
            shift_count_in = sc_sat;
            if (sc_sat >= shift_period_ff) begin
               shift_count_in = sc_sat - shift_period_ff;
               shift_reg_in   = ((shift_reg_ff >> 1) & ~fb_mask)
                                | (fb_bit ? fb_mask : '0);
            end
         end
         // Length expiry stops the channel and skips the envelope
         if (length_active_ff && (lc_sum >= length_limit_ff)) begin
            length_count_in  = lc_sum;
            length_active_in = 1'b0;
            running_in       = 1'b0;
         end else begin
            if (length_active_ff) begin
               length_count_in = lc_sum;
            end
            if (envelope_active_ff) begin
               if (envelope_step_ff == 3'd0) begin
                  envelope_active_in = 1'b0;
               end else if (env_sum >= env_step_ticks) begin
                  volume_in          = envelope_dir_ff ? (volume_ff + 4'd1)
                                                       : (volume_ff - 4'd1);
                  envelope_active_in = (volume_in != 4'd0);
                  envelope_count_in  = ENV_CNT_W'(env_sum - env_step_ticks);
               end else begin
                  envelope_count_in  = env_sum[ENV_CNT_W-1:0];
               end
            end
         end
      end
   end

   // Result from the updated state
   always_comb begin
      magnitude         = {volume_in, 7'b0000000};
      mag_ext           = {1'b0, magnitude};
      result.channel_on = running_in;
      result.noise_bit  = shift_reg_in[0];
      if (!running_in) begin
         result.sample = '0;
      end else if (shift_reg_in[0]) begin
         result.sample = mag_ext;
      end else begin
         result.sample = {SAMPLE_W{1'b0}} - mag_ext;
      end
   end

   // Channel state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff         <= 1'b0;
         shift_reg_ff       <= LFSR_RESET;
         shift_period_ff    <= SHIFT_PERIOD_RESET;
         shift_count_ff     <= '0;
         short_latched_ff   <= 1'b0;
         length_active_ff   <= 1'b0;
         length_limit_ff    <= LENGTH_LIMIT_RESET;
         length_count_ff    <= '0;
         envelope_active_ff <= 1'b0;
         envelope_dir_ff    <= 1'b0;
         envelope_step_ff   <= '0;
         envelope_count_ff  <= '0;
         volume_ff          <= '0;
      end else if (req_take) begin
         running_ff         <= running_in;
         shift_reg_ff       <= shift_reg_in;
         shift_period_ff    <= shift_period_in;
         shift_count_ff     <= shift_count_in;
         short_latched_ff   <= short_latched_in;
         length_active_ff   <= length_active_in;
         length_limit_ff    <= length_limit_in;
         length_count_ff    <= length_count_in;
         envelope_active_ff <= envelope_active_in;
         envelope_dir_ff    <= envelope_dir_in;
         envelope_step_ff   <= envelope_step_in;
         envelope_count_ff  <= envelope_count_in;
         volume_ff          <= volume_in;
      end
   end

   // Output register and skid entry steering
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in  = req_take;
            rsp_data_in   = result;
         end
      end else if (req_take) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample     = $signed(rsp_data_ff.sample);
   assign rsp_channel_on = rsp_data_ff.channel_on;
   assign rsp_noise_bit  = rsp_data_ff.noise_bit;

   // Checks
   // The skid entry only fills behind a held output register
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry full with empty output register");

   // A stopped channel reports silence
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_channel_on) |-> (rsp_sample == '0))
      else $error("nonzero sample while channel stopped");

   // The envelope counter stays below one envelope step
   assert property (@(posedge clock) disable iff (reset)
      envelope_active_ff |-> ({1'b0, envelope_count_ff} < env_step_ticks))
      else $error("envelope counter past its step");

   // The LFSR only moves while the channel runs
   assert property (@(posedge clock) disable iff (reset)
      !running_ff |=> $stable(shift_reg_ff))
      else $error("LFSR moved while channel stopped");

endmodule
